### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define SEM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/sem_pkg.sv
// shared constants and types of the sobel edge magnitude block
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int PIX_W      = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = FPTR_W + 1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // masked 3x3 window, tap 4 is the center, taps 2/5/8 the newest column
  typedef struct packed {
    pixel_t [8:0] win;
    logic         last;
  } job_t;

endpackage

### sv/sobel_edge_magnitude_rgb.sv
// top level of the rgb sobel edge magnitude block
// a result is made from the window that one input beat completes
// (window one row plus one pixel behind the input stream)
// the back end takes a job only when idle, after its square, root and done states;
// the front end takes one beat a cycle until the four-entry job queue fills
// reset: synchronous active-low; width 640, height 480, positions and window cleared
// line stores are not cleared; entries never written are masked at the frame border
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_cmd,
  input  logic [7:0]  in_pixel_red,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_blue,
  // result beats
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_edge_red,
  output logic [7:0]  out_edge_green,
  output logic [7:0]  out_edge_blue,
  output logic        out_frame_last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // job queue wiring
  logic              job_push;
  job_t              job_in;
  logic              q_pop;
  job_t              q_head;
  logic              q_empty;
  logic [FCNT_W-1:0] q_level;

  // register writes are always accepted and land in the next cycle
  assign cfg_ready = 1'b1;

  // positions, line stores and the window; emits masked windows
  sem_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_cmd         (in_cmd),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_full        (in_full),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fifo_level     (q_level),
    .job_push       (job_push),
    .job            (job_in)
  );

  // decouples the streaming front from the multi-cycle back end
  sem_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty),
    .level    (q_level)
  );

  // gradients, magnitude and the result register
  sem_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_edge_red   (out_edge_red),
    .out_edge_green (out_edge_green),
    .out_edge_blue  (out_edge_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

### sv/sem_fifo.sv
// short job queue between the window front end and the magnitude back end
`include "assert_macros.svh"
module sem_fifo
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  job_t              push_job,
  input  logic              pop,
  output job_t              head_job,
  output logic              empty,
  output logic [FCNT_W-1:0] level
);

  job_t              mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r;
  logic [FPTR_W-1:0] rd_ptr_r;
  logic [FCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + FCNT_W'(push) - FCNT_W'(pop);
    end
  end

  assign head_job = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign level    = cnt_r;

  `SEM_NEVER(a_fifo_overflow, push && !pop && (cnt_r == FCNT_W'(FIFO_DEPTH)), "job queue overflow")
  `SEM_NEVER(a_fifo_underflow, pop && (cnt_r == '0), "job queue underflow")
  `SEM_NEVER(a_fifo_level_range, cnt_r > FCNT_W'(FIFO_DEPTH), "job queue count out of range")

endmodule

### sv/sem_front.sv
// front end: positions, line stores, 3x3 window and border masks
`include "assert_macros.svh"
module sem_front
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_cmd,
  input  logic [7:0]        in_pixel_red,
  input  logic [7:0]        in_pixel_green,
  input  logic [7:0]        in_pixel_blue,
  output logic              in_full,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [FCNT_W-1:0] fifo_level,
  output logic              job_push,
  output job_t              job
);

  logic [WID_W-1:0]   fw_r;
  logic [ROW_W-1:0]   fh_r;
  logic [COL_W-1:0]   in_col_r;
  logic [ROW_W-1:0]   in_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-2:0]   out_row_r;

  logic               s1_vld_r, s1_emit_r, s1_last_r, s1_byp_r;
  logic [8:0]         s1_mask_r;
  pixel_t             s1_pix_r;
  logic [COL_W-1:0]   s1_addr_r;
  pixel_t             prev_mid_r, prev_pix_r;
  pixel_t [8:0]       win_r;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [WID_W-1:0]   w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic               frame_in, ignore, take, emit, last, col_wrap;
  logic               tv, bv, lv, rv;
  logic [8:0]         mask;
  pixel_t             new_pix, top_eff, mid_eff;
  pixel_t [8:0]       win_nxt;
  logic               cfg_hit;

  always_comb begin
    priority if (fw_r == '0)                    w_eff = WID_W'(1);
    else if (fw_r > WID_W'(MAX_WIDTH))          w_eff = WID_W'(MAX_WIDTH);
    else                                        w_eff = fw_r;
    priority if (fh_r == '0)                    h_eff = ROW_W'(1);
    else if (fh_r > ROW_W'(MAX_HEIGHT))         h_eff = ROW_W'(MAX_HEIGHT);
    else                                        h_eff = fh_r;
  end

  always_comb begin
    frame_in = (in_row_r >= h_eff);
    ignore   = !frame_in && (in_cmd == CMD_DRAIN);
    in_full  = ({1'b0, fifo_level} + (FCNT_W + 1)'(s1_vld_r && s1_emit_r))
               >= (FCNT_W + 1)'(FIFO_DEPTH);
    take     = in_push && !in_full && !ignore;
    new_pix  = frame_in ? '0 : {in_pixel_blue, in_pixel_green, in_pixel_red};
    emit     = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    col_wrap = ({1'b0, in_col_r} + WID_W'(1)) >= w_eff;
    tv       = (out_row_r != '0);
    bv       = ({1'b0, out_row_r} + ROW_W'(1)) < h_eff;
    lv       = (out_col_r != '0);
    rv       = ({1'b0, out_col_r} + WID_W'(1)) < w_eff;
    mask     = {bv && rv, bv, bv && lv, rv, 1'b1, lv, tv && rv, tv, tv && lv};
    last     = !bv && !rv;
    cfg_hit  = cfg_valid && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));
  end

  // line store: upper half is the row above the middle row
  always_ff @(posedge clk) begin
    if (take) rd_q <= line_mem[in_col_r];
    if (s1_vld_r) line_mem[s1_addr_r] <= {mid_eff, s1_pix_r};
  end

  always_comb begin
    top_eff = s1_byp_r ? prev_mid_r : rd_q[2*PIX_W-1:PIX_W];
    mid_eff = s1_byp_r ? prev_pix_r : rd_q[PIX_W-1:0];
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_eff;
    win_nxt[5] = mid_eff;
    win_nxt[8] = s1_pix_r;
    job_push = s1_vld_r && s1_emit_r;
    job.last = s1_last_r;
    for (int i = 0; i < 9; i++) begin
      job.win[i] = s1_mask_r[i] ? win_nxt[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r  <= new_pix;
      s1_addr_r <= in_col_r;
      s1_mask_r <= mask;
      s1_last_r <= last;
      s1_emit_r <= emit;
    end
    if (s1_vld_r) begin
      prev_mid_r <= mid_eff;
      prev_pix_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= WID_W'(640);
      fh_r      <= ROW_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_vld_r  <= 1'b0;
      s1_byp_r  <= 1'b0;
      win_r     <= '0;
    end else begin
      s1_vld_r <= take;
      s1_byp_r <= take && s1_vld_r && (s1_addr_r == in_col_r);
      if (s1_vld_r) win_r <= win_nxt;
      if (cfg_hit) begin
        if (cfg_index == CFG_WIDTH) fw_r <= cfg_data[WID_W-1:0];
        else                        fh_r <= cfg_data[ROW_W-1:0];
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else if (take) begin
        if (emit && last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          if (col_wrap) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
          end
          if (emit) begin
            if (rv) out_col_r <= out_col_r + 1'b1;
            else begin
              out_col_r <= '0;
              out_row_r <= out_row_r + 1'b1;
            end
          end
        end
      end
    end
  end

  `SEM_ASSERT(a_bypass_after_take, s1_byp_r |-> s1_vld_r, "bypass without a beat in flight")
  `SEM_NEVER(a_in_col_range, {1'b0, in_col_r} >= w_eff, "input column past row end")
  `SEM_NEVER(a_job_overfill, job_push && (fifo_level == FCNT_W'(FIFO_DEPTH)), "job into full queue")

endmodule

### sv/sem_back.sv
// back end: sobel gradients, squared magnitude and bitwise square root
`include "assert_macros.svh"
module sem_back
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_edge_red,
  output logic [7:0] out_edge_green,
  output logic [7:0] out_edge_blue,
  output logic       out_frame_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_ROOT, ST_DONE} state_t;

  state_t                  state_r;
  logic signed [10:0]      gx_r [3];
  logic signed [10:0]      gy_r [3];
  logic [20:0]             sum_r [3];
  logic [7:0]              root_r [3];
  logic [2:0]              step_r;
  logic                    last_r;
  logic                    out_vld_r;
  logic [7:0]              edge_r [3];
  logic                    flast_r;

  logic signed [10:0]      gx_c [3];
  logic signed [10:0]      gy_c [3];
  logic [7:0]              try_c [3];
  logic [7:0]              bit_c;
  logic [10:0]             v [9];
  logic                    out_free;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        v[i] = {3'b000, q_head.win[i][c*8 +: 8]};
      end
      gx_c[c] = $signed(v[2]) - $signed(v[0]) + (($signed(v[5]) - $signed(v[3])) <<< 1)
              + $signed(v[8]) - $signed(v[6]);
      gy_c[c] = $signed(v[6]) - $signed(v[0]) + (($signed(v[7]) - $signed(v[1])) <<< 1)
              + $signed(v[8]) - $signed(v[2]);
    end
    bit_c = 8'h80 >> step_r;
    for (int c = 0; c < 3; c++) begin
      try_c[c] = root_r[c] | bit_c;
    end
    out_free = !out_vld_r || out_pop;
    q_pop    = (state_r == ST_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      step_r    <= '0;
    end else begin
      if (out_pop && !((state_r == ST_DONE) && out_free)) out_vld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            gx_r   <= gx_c;
            gy_r   <= gy_c;
            last_r <= q_head.last;
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          for (int c = 0; c < 3; c++) begin
            sum_r[c]  <= 21'(gx_r[c] * gx_r[c]) + 21'(gy_r[c] * gy_r[c]);
            root_r[c] <= '0;
          end
          step_r  <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          // one result bit per cycle, msb first
          for (int c = 0; c < 3; c++) begin
            if (21'(try_c[c] * try_c[c]) <= sum_r[c]) root_r[c] <= try_c[c];
          end
          step_r <= step_r + 1'b1;
          if (step_r == 3'd7) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            for (int c = 0; c < 3; c++) begin
              edge_r[c] <= (sum_r[c] >= 21'd65536) ? 8'd255 : root_r[c];
            end
            flast_r   <= last_r;
            out_vld_r <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty      = !out_vld_r;
  assign out_edge_red   = edge_r[0];
  assign out_edge_green = edge_r[1];
  assign out_edge_blue  = edge_r[2];
  assign out_frame_last = flast_r;

  `SEM_ASSERT(a_result_held, (out_vld_r && !out_pop) |=> out_vld_r, "result dropped before pop")
  `SEM_NEVER(a_pop_only_idle, q_pop && (state_r != ST_IDLE), "job taken while busy")
  `SEM_ASSERT(a_root_steps, (state_r == ST_ROOT && step_r == 3'd7) |=> (state_r == ST_DONE), "root overrun")

endmodule
